// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the flux unit RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ===== hdl/hll_pkg.sv =====
// Package for the HLL flux unit: payload structs, Q16.16 constants and
// saturating fixed-point helpers. No dependencies.
package hll_pkg;

    localparam int SpaceDims = 2;
    localparam int Frac      = 16;

    localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QMin = 32'sh8000_0000;

    typedef logic signed [31:0] t_q;

    typedef struct packed {
        logic [30:0]        left_density;
        logic signed [31:0] left_velocity_0;
        logic signed [31:0] left_velocity_1;
        logic [30:0]        left_internal_energy;
        logic [30:0]        left_pressure;
        logic [30:0]        left_sound_speed;
        logic [30:0]        right_density;
        logic signed [31:0] right_velocity_0;
        logic signed [31:0] right_velocity_1;
        logic [30:0]        right_internal_energy;
        logic [30:0]        right_pressure;
        logic [30:0]        right_sound_speed;
    } t_req;

    typedef struct packed {
        logic signed [31:0] mass_flux;
        logic signed [31:0] momentum_flux_0;
        logic signed [31:0] momentum_flux_1;
        logic signed [31:0] energy_flux;
    } t_rsp;

    // Saturate a 34-bit sum to Q16.16.
    function automatic t_q sat34(input logic signed [33:0] x);
        t_q r;
        if (x > 34'(QMax)) r = QMax;
        else if (x < 34'(QMin)) r = QMin;
        else r = x[31:0];
        return r;
    endfunction

    // Q16.16 product: floor shift, then saturate.
    function automatic t_q qmul(input t_q a, input t_q b);
        logic signed [63:0] p;
        logic signed [47:0] s;
        t_q r;
        p = 64'(a) * 64'(b);
        s = p[63:16];
        if (s > 48'(QMax)) r = QMax;
        else if (s < 48'(QMin)) r = QMin;
        else r = s[31:0];
        return r;
    endfunction

endpackage

// ===== hdl/hll_div.sv =====
// Pipelined restoring divider: signed numerator by positive denominator,
// truncating toward zero, saturated to Q16.16. Uses hll_pkg.
module hll_div #(
    parameter int NumW = 52
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  logic signed [NumW-1:0] i_num,
    input  logic [31:0]            i_den,
    output logic                   o_vld,
    output logic signed [31:0]     o_quo
);
    localparam int Steps = NumW;
    localparam int Per   = 4;
    localparam int Stg   = (Steps + Per - 1) / Per;
    localparam int RemW  = 33;

    logic [Stg:0]           r_vld;
    logic [NumW-1:0]        r_mag [Stg+1];
    logic [RemW-1:0]        r_rem [Stg+1];
    logic [31:0]            r_den [Stg+1];
    logic [Stg:0]           r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[Stg-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag[0] <= i_num[NumW-1] ? NumW'(-i_num) : NumW'(i_num);
        r_neg[0] <= i_num[NumW-1];
        r_rem[0] <= '0;
        r_den[0] <= i_den;
    end

    for (genvar g = 0; g < Stg; g++) begin : g_stage
        logic [NumW-1:0] n_mag;
        logic [RemW-1:0] n_rem;
        always_comb begin
            logic [RemW:0] t;
            n_mag = r_mag[g];
            n_rem = r_rem[g];
            for (int k = 0; k < Per; k++) begin
                if (g * Per + k < Steps) begin
                    t = {n_rem, n_mag[NumW-1]};
                    n_mag = {n_mag[NumW-2:0], 1'b0};
                    if (t >= (RemW+1)'(r_den[g])) begin
                        t = t - (RemW+1)'(r_den[g]);
                        n_mag[0] = 1'b1;
                    end
                    n_rem = t[RemW-1:0];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_mag[g+1] <= n_mag;
            r_rem[g+1] <= n_rem;
            r_den[g+1] <= r_den[g];
            r_neg[g+1] <= r_neg[g];
        end
    end

    logic [NumW-1:0] w_q;
    assign w_q = r_mag[Stg];
    always_comb begin
        if (r_neg[Stg]) begin
            if (w_q > NumW'(33'h0_8000_0000)) o_quo = hll_pkg::QMin;
            else o_quo = 32'(-w_q);
        end else begin
            if (w_q > NumW'(32'h7FFF_FFFF)) o_quo = hll_pkg::QMax;
            else o_quo = w_q[31:0];
        end
    end
    assign o_vld = r_vld[Stg];
endmodule

// ===== hdl/hll_euler_flux_unit.sv =====
// Top level of the HLL Euler interface flux unit: side fluxes, wave speeds,
// HLL mix and division. Uses hll_pkg, hll_div and assert_macros.svh.
//
//  channel   signals                      direction  handshake
//  request   i_start, o_busy, i_req       in         start & !busy
//  result    o_rsp_vld, o_rsp             out        strobe, one cycle
//  config    i_cfg_valid, o_cfg_ready,    in         valid & ready
//            i_cfg_data
//
// One request per cycle enters; the result passes through seven front stages,
// the divider's 14 stages and one output register.
// Busy is always low after reset, as the receiver cannot stall and every
// stage advances each cycle. Reset clears valid bits and sweep_axis only.
`include "assert_macros.svh"
module hll_euler_flux_unit #(
    parameter int SPACE_DIMS = hll_pkg::SpaceDims
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  hll_pkg::t_req  i_req,
    output logic           o_rsp_vld,
    output hll_pkg::t_rsp  o_rsp,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_data
);
    localparam int NumW = 52;
    typedef logic signed [31:0] t_q;
    typedef logic signed [33:0] t_w;

    logic r_axis;
    logic w_acc;
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_axis <= 1'b0;
        else if (i_cfg_valid && o_cfg_ready) r_axis <= i_cfg_data;
    end

    logic w_ax;
    assign w_ax = (SPACE_DIMS < 2) ? 1'b0 : r_axis;

    // Stage 1: capture and velocity squares.
    logic       r_v1;
    t_q         r1_rho [2], r1_v0 [2], r1_v1 [2], r1_e [2], r1_p [2], r1_c [2];
    t_q         r1_s0 [2], r1_s1 [2];
    logic       r1_ax;
    always_ff @(posedge i_clk) begin
        t_q v0 [2], v1 [2];
        v0[0] = i_req.left_velocity_0;
        v0[1] = i_req.right_velocity_0;
        v1[0] = (SPACE_DIMS > 1) ? i_req.left_velocity_1 : '0;
        v1[1] = (SPACE_DIMS > 1) ? i_req.right_velocity_1 : '0;
        r1_rho[0] <= {1'b0, i_req.left_density};
        r1_rho[1] <= {1'b0, i_req.right_density};
        r1_e[0]   <= {1'b0, i_req.left_internal_energy};
        r1_e[1]   <= {1'b0, i_req.right_internal_energy};
        r1_p[0]   <= {1'b0, i_req.left_pressure};
        r1_p[1]   <= {1'b0, i_req.right_pressure};
        r1_c[0]   <= {1'b0, i_req.left_sound_speed};
        r1_c[1]   <= {1'b0, i_req.right_sound_speed};
        r1_ax     <= w_ax;
        for (int s = 0; s < 2; s++) begin
            r1_v0[s] <= v0[s];
            r1_v1[s] <= v1[s];
            r1_s0[s] <= hll_pkg::qmul(v0[s], v0[s]);
            r1_s1[s] <= hll_pkg::qmul(v1[s], v1[s]);
        end
    end

    // Stage 2: specific energy, momenta, mass flux.
    logic r_v2;
    t_q   r2_rho [2], r2_vn [2], r2_p [2], r2_c [2], r2_es [2];
    t_q   r2_m0 [2], r2_m1 [2], r2_fm [2];
    logic r2_ax;
    always_ff @(posedge i_clk) begin
        t_q mag, vn;
        for (int s = 0; s < 2; s++) begin
            mag = hll_pkg::sat34(t_w'(r1_s0[s]) + t_w'(r1_s1[s]));
            vn  = r1_ax ? r1_v1[s] : r1_v0[s];
            r2_es[s] <= hll_pkg::sat34(t_w'(r1_e[s]) + t_w'(mag >>> 1));
            r2_m0[s] <= hll_pkg::qmul(r1_v0[s], r1_rho[s]);
            r2_m1[s] <= hll_pkg::qmul(r1_v1[s], r1_rho[s]);
            r2_fm[s] <= hll_pkg::qmul(r1_rho[s], vn);
            r2_vn[s] <= vn;
            r2_rho[s] <= r1_rho[s];
            r2_p[s]  <= r1_p[s];
            r2_c[s]  <= r1_c[s];
        end
        r2_ax <= r1_ax;
    end

    // Stage 3: total energy, momentum fluxes, wave speed candidates.
    logic r_v3;
    t_q   r3_rho [2], r3_vn [2], r3_p [2], r3_et [2], r3_m0 [2], r3_m1 [2];
    t_q   r3_fm [2], r3_f0 [2], r3_f1 [2], r3_lo [2], r3_hi [2];
    logic r3_ax;
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < 2; s++) begin
            r3_et[s] <= hll_pkg::qmul(r2_rho[s], r2_es[s]);
            r3_f0[s] <= hll_pkg::qmul(r2_m0[s], r2_vn[s]);
            r3_f1[s] <= hll_pkg::qmul(r2_m1[s], r2_vn[s]);
            r3_lo[s] <= hll_pkg::sat34(t_w'(r2_vn[s]) - t_w'(r2_c[s]));
            r3_hi[s] <= hll_pkg::sat34(t_w'(r2_vn[s]) + t_w'(r2_c[s]));
            r3_rho[s] <= r2_rho[s];
            r3_vn[s] <= r2_vn[s];
            r3_p[s]  <= r2_p[s];
            r3_m0[s] <= r2_m0[s];
            r3_m1[s] <= r2_m1[s];
            r3_fm[s] <= r2_fm[s];
        end
        r3_ax <= r2_ax;
    end

    // Stage 4: pressure terms, wave speeds.
    logic r_v4;
    t_q   r4_vn [2], r4_ep [2], r4_u [2][4], r4_f [2][3];
    t_q   r4_sl, r4_sr;
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < 2; s++) begin
            r4_ep[s] <= hll_pkg::sat34(t_w'(r3_et[s]) + t_w'(r3_p[s]));
            r4_f[s][0] <= r3_fm[s];
            r4_f[s][1] <= r3_ax ? r3_f0[s]
                                : hll_pkg::sat34(t_w'(r3_f0[s]) + t_w'(r3_p[s]));
            r4_f[s][2] <= r3_ax ? hll_pkg::sat34(t_w'(r3_f1[s]) + t_w'(r3_p[s]))
                                : r3_f1[s];
            r4_u[s][0] <= r3_rho[s];
            r4_u[s][1] <= r3_m0[s];
            r4_u[s][2] <= r3_m1[s];
            r4_u[s][3] <= r3_et[s];
            r4_vn[s] <= r3_vn[s];
        end
        r4_sl <= (r3_lo[0] < r3_lo[1]) ? r3_lo[0] : r3_lo[1];
        r4_sr <= (r3_hi[0] > r3_hi[1]) ? r3_hi[0] : r3_hi[1];
    end

    // Stage 5: energy flux, sR*sL, conserved differences.
    logic r_v5;
    t_q   r5_fl [4], r5_fr [4], r5_du [4], r5_sl, r5_sr, r5_slr;
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r5_fl[j] <= r4_f[0][j];
            r5_fr[j] <= r4_f[1][j];
        end
        r5_fl[3] <= hll_pkg::qmul(r4_vn[0], r4_ep[0]);
        r5_fr[3] <= hll_pkg::qmul(r4_vn[1], r4_ep[1]);
        for (int j = 0; j < 4; j++)
            r5_du[j] <= hll_pkg::sat34(t_w'(r4_u[1][j]) - t_w'(r4_u[0][j]));
        r5_slr <= hll_pkg::qmul(r4_sr, r4_sl);
        r5_sl  <= r4_sl;
        r5_sr  <= r4_sr;
    end

    // Stage 6: the three products of each HLL numerator.
    logic r_v6;
    t_q   r6_a [4], r6_b [4], r6_c [4], r6_fl [4], r6_fr [4];
    t_q   r6_sl, r6_sr;
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            r6_a[j]  <= hll_pkg::qmul(r5_sr, r5_fl[j]);
            r6_b[j]  <= hll_pkg::qmul(r5_sl, r5_fr[j]);
            r6_c[j]  <= hll_pkg::qmul(r5_slr, r5_du[j]);
            r6_fl[j] <= r5_fl[j];
            r6_fr[j] <= r5_fr[j];
        end
        r6_sl <= r5_sl;
        r6_sr <= r5_sr;
    end

    // Stage 7: numerator sums, branch decision, denominator.
    logic              r_v7;
    logic signed [NumW-1:0] r7_num [4];
    logic [31:0]       r7_den;
    logic              r7_mix;
    t_q                r7_byp [4];
    always_ff @(posedge i_clk) begin
        logic signed [33:0] sum;
        for (int j = 0; j < 4; j++) begin
            sum = t_w'(r6_a[j]) - t_w'(r6_b[j]) + t_w'(r6_c[j]);
            r7_num[j] <= {NumW'(sum)} << 16;
            r7_byp[j] <= (r6_sl >= 0) ? r6_fl[j] : r6_fr[j];
        end
        r7_den <= 32'(t_w'(r6_sr) - t_w'(r6_sl));
        r7_mix <= !(r6_sl >= 0) && !(r6_sr <= 0);
    end

    // The divider latency is matched by a delay line on the bypass path.
    localparam int DivLat = (NumW + 3) / 4 + 1;
    logic        w_dvld [4];
    t_q          w_quo [4];
    for (genvar j = 0; j < 4; j++) begin : g_div
        hll_div #(.NumW(NumW)) u_div (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (r_v7),
            .i_num  (r7_num[j]),
            .i_den  (r7_den),
            .o_vld  (w_dvld[j]),
            .o_quo  (w_quo[j])
        );
    end

    logic   r_dmix [DivLat];
    t_q     r_dbyp [DivLat][4];
    always_ff @(posedge i_clk) begin
        r_dmix[0] <= r7_mix;
        r_dbyp[0] <= r7_byp;
        for (int k = 1; k < DivLat; k++) begin
            r_dmix[k] <= r_dmix[k-1];
            r_dbyp[k] <= r_dbyp[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_v5 <= 1'b0; r_v6 <= 1'b0; r_v7 <= 1'b0; o_rsp_vld <= 1'b0;
        end else begin
            r_v1 <= w_acc; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
            r_v5 <= r_v4; r_v6 <= r_v5; r_v7 <= r_v6; o_rsp_vld <= w_dvld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        t_q r [4];
        for (int j = 0; j < 4; j++)
            r[j] = r_dmix[DivLat-1] ? w_quo[j] : r_dbyp[DivLat-1][j];
        o_rsp.mass_flux       <= r[0];
        o_rsp.momentum_flux_0 <= r[1];
        o_rsp.momentum_flux_1 <= (SPACE_DIMS < 2) ? '0 : r[2];
        o_rsp.energy_flux     <= r[3];
    end

    `ASSERT_IMPL(a_div_lanes, i_clk, i_rst_n, (w_dvld[0] == w_dvld[3]))
    `ASSERT_NEXT(a_mix_den, i_clk, i_rst_n, r_v6 && !(r6_sl >= 0) && !(r6_sr <= 0), r7_den != 0)
    `ASSERT_NEXT(a_front, i_clk, i_rst_n, w_acc, r_v1)
    `ASSERT_NEXT(a_out, i_clk, i_rst_n, w_dvld[0], o_rsp_vld)
endmodule

// ===== test/hll_flux_checker.sv =====
// Checker for the HLL flux unit: watches the request, result and config channels,
// predicts each flux in Q16.16 and compares the results in order.
// Depends on hll_pkg for the payload structs.
module hll_flux_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  hll_pkg::t_req i_req,
    input  logic          i_rsp_vld,
    input  hll_pkg::t_rsp i_rsp,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic          i_cfg_data,
    output int            o_errors,
    output int            o_pending
);
    localparam longint Hi = 64'sd2147483647;
    localparam longint Lo = -64'sd2147483648;

    typedef struct {
        longint rho, p, c, vn, etot, fmass, fen;
        longint vel[2], mom[2], fmom[2];
    } t_cell;

    bit              axis;
    hll_pkg::t_rsp   flux_q[$];
    int              errors;
    int              pending_cnt;

    function automatic longint clamp(longint x);
        if (x > Hi) return Hi;
        if (x < Lo) return Lo;
        return x;
    endfunction

    // Arithmetic shift gives the floor of the scaled product.
    function automatic longint fmul(longint a, longint b);
        longint p;
        p = a * b;
        return clamp(p >>> 16);
    endfunction

    function automatic t_cell cell_state(longint rho, longint v0, longint v1, longint ie,
                                         longint p, longint c, bit ax);
        t_cell s;
        longint mag2, espec;
        s.rho = rho; s.p = p; s.c = c;
        s.vel[0] = v0; s.vel[1] = v1;
        mag2 = clamp(fmul(v0, v0));
        mag2 = clamp(mag2 + fmul(v1, v1));
        espec = clamp(ie + mag2 / 2);
        s.etot = fmul(rho, espec);
        s.vn = s.vel[ax];
        s.fmass = fmul(rho, s.vn);
        for (int k = 0; k < 2; k++) begin
            s.mom[k] = fmul(s.vel[k], rho);
            s.fmom[k] = fmul(s.mom[k], s.vn);
        end
        s.fmom[ax] = clamp(s.fmom[ax] + p);
        s.fen = fmul(s.vn, clamp(s.etot + p));
        return s;
    endfunction

    function automatic logic signed [31:0] hll_average(longint sl, longint sr, longint slr,
                                                      longint fl, longint fr,
                                                      longint ul, longint ur);
        longint num;
        num = fmul(sr, fl) - fmul(sl, fr) + fmul(slr, clamp(ur - ul));
        return 32'(clamp((num * 65536) / (sr - sl)));
    endfunction

    function automatic hll_pkg::t_rsp interface_flux(hll_pkg::t_req r, bit ax);
        t_cell a, b;
        longint sl, sr, t1, t2, slr;
        hll_pkg::t_rsp f;
        a = cell_state(longint'(r.left_density), longint'(r.left_velocity_0),
                       longint'(r.left_velocity_1), longint'(r.left_internal_energy),
                       longint'(r.left_pressure), longint'(r.left_sound_speed), ax);
        b = cell_state(longint'(r.right_density), longint'(r.right_velocity_0),
                       longint'(r.right_velocity_1), longint'(r.right_internal_energy),
                       longint'(r.right_pressure), longint'(r.right_sound_speed), ax);
        t1 = clamp(a.vn - a.c);
        t2 = clamp(b.vn - b.c);
        sl = (t1 < t2) ? t1 : t2;
        t1 = clamp(a.vn + a.c);
        t2 = clamp(b.vn + b.c);
        sr = (t1 > t2) ? t1 : t2;
        if (sl >= 0) begin
            f = '{a.fmass[31:0], a.fmom[0][31:0], a.fmom[1][31:0], a.fen[31:0]};
        end else if (sr <= 0) begin
            f = '{b.fmass[31:0], b.fmom[0][31:0], b.fmom[1][31:0], b.fen[31:0]};
        end else begin
            slr = fmul(sr, sl);
            f.mass_flux       = hll_average(sl, sr, slr, a.fmass, b.fmass, a.rho, b.rho);
            f.momentum_flux_0 = hll_average(sl, sr, slr, a.fmom[0], b.fmom[0],
                                            a.mom[0], b.mom[0]);
            f.momentum_flux_1 = hll_average(sl, sr, slr, a.fmom[1], b.fmom[1],
                                            a.mom[1], b.mom[1]);
            f.energy_flux     = hll_average(sl, sr, slr, a.fen, b.fen, a.etot, b.etot);
        end
        return f;
    endfunction

    task automatic report(string what, hll_pkg::t_rsp want, hll_pkg::t_rsp got);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected %h %h %h %h, actual %h %h %h %h", what,
                     want.mass_flux, want.momentum_flux_0, want.momentum_flux_1,
                     want.energy_flux, got.mass_flux, got.momentum_flux_0,
                     got.momentum_flux_1, got.energy_flux);
    endtask

    initial begin
        axis = 1'b0;
        errors = 0;
        pending_cnt = 0;
    end

    always @(posedge i_clk) begin
        hll_pkg::t_rsp want;
        if (!i_rst_n) begin
            axis = 1'b0;
        end else begin
            // A request taken at this edge still sees the axis in force before it.
            if (i_start && !i_busy)
                flux_q.insert(flux_q.size(), interface_flux(i_req, axis));
            if (i_cfg_valid && i_cfg_ready) axis = i_cfg_data;
            if (i_rsp_vld) begin
                if (flux_q.size() == 0) begin
                    report("unexpected result", '0, i_rsp);
                end else begin
                    want = flux_q.pop_front();
                    if (want !== i_rsp) report("flux", want, i_rsp);
                end
            end
        end
        pending_cnt = flux_q.size();
    end

    assign o_errors  = errors;
    assign o_pending = pending_cnt;
endmodule

// ===== test/tb_hll_euler_flux_unit.sv =====
// Testbench top for hll_euler_flux_unit: drives directed and random requests
// and sweep axis writes, and takes the verdict from hll_flux_checker.
// Depends on hll_pkg, the unit RTL and test/hll_flux_checker.sv.
module tb_hll_euler_flux_unit;
    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_start = 1'b0;
    logic          o_busy;
    hll_pkg::t_req i_req = '0;
    logic          o_rsp_vld;
    hll_pkg::t_rsp o_rsp;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic          i_cfg_data = 1'b0;
    int            errors;
    int            pending;

    always #2 i_clk = ~i_clk;

    hll_euler_flux_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_req(i_req), .o_rsp_vld(o_rsp_vld), .o_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    hll_flux_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_req(i_req), .i_rsp_vld(o_rsp_vld), .i_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(hll_pkg::t_req r, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    // The pipeline is 22 stages deep, so let it drain before a write.
    task automatic write_axis(bit v);
        i_start <= 1'b0;
        wait (pending == 0);
        repeat (30) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [30:0] rand_scalar();
        case ($urandom_range(9))
            0: return '0;
            1: return 31'h7FFF_FFFF;
            2, 3: return 31'($urandom);
            default: return 31'($urandom_range(0, 20 << 16));
        endcase
    endfunction

    function automatic logic signed [31:0] rand_velocity();
        logic signed [31:0] v;
        case ($urandom_range(9))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7FFF_FFFF;
            2, 3: v = $urandom;
            default: v = $urandom_range(0, 40 << 16);
        endcase
        if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    function automatic hll_pkg::t_req rand_request();
        hll_pkg::t_req r;
        r.left_density = rand_scalar();
        r.left_velocity_0 = rand_velocity();
        r.left_velocity_1 = rand_velocity();
        r.left_internal_energy = rand_scalar();
        r.left_pressure = rand_scalar();
        r.left_sound_speed = rand_scalar();
        r.right_density = rand_scalar();
        r.right_velocity_0 = rand_velocity();
        r.right_velocity_1 = rand_velocity();
        r.right_internal_energy = rand_scalar();
        r.right_pressure = rand_scalar();
        r.right_sound_speed = rand_scalar();
        return r;
    endfunction

    // A calm pair with the given normal velocities and sound speed, in whole units.
    function automatic hll_pkg::t_req flow_request(int vl, int vr, int c, bit ax);
        hll_pkg::t_req r;
        r = '0;
        r.left_density = 31'(2 << 16);
        r.right_density = 31'(1 << 16);
        r.left_internal_energy = 31'(3 << 16);
        r.right_internal_energy = 31'(1 << 16);
        r.left_pressure = 31'(4 << 16);
        r.right_pressure = 31'(1 << 16);
        r.left_sound_speed = 31'(c << 16);
        r.right_sound_speed = 31'(c << 16);
        r.left_velocity_0 = ax ? 32'sh0000_8000 : 32'(vl <<< 16);
        r.left_velocity_1 = ax ? 32'(vl <<< 16) : -32'sh0000_8000;
        r.right_velocity_0 = ax ? 32'sh0001_0000 : 32'(vr <<< 16);
        r.right_velocity_1 = ax ? 32'(vr <<< 16) : 32'sh0000_4000;
        return r;
    endfunction

    task automatic directed_set(bit ax);
        hll_pkg::t_req r;
        send_request('0, 0);
        send_request('1, 0);
        r = '1;
        r.left_velocity_0 = 32'sh8000_0000; r.left_velocity_1 = 32'sh8000_0000;
        r.right_velocity_0 = 32'sh8000_0000; r.right_velocity_1 = 32'sh8000_0000;
        send_request(r, 0);
        r = '0;
        r.left_velocity_0 = 32'sh7FFF_FFFF; r.right_velocity_1 = 32'sh8000_0000;
        r.left_sound_speed = 31'h7FFF_FFFF; r.right_density = 31'h7FFF_FFFF;
        send_request(r, 0);
        send_request(flow_request(5, 6, 1, ax), 0);
        send_request(flow_request(-5, -6, 1, ax), 0);
        send_request(flow_request(1, -1, 2, ax), 0);
        send_request(flow_request(2, 3, 2, ax), 0);
        send_request(flow_request(0, 0, 0, ax), 0);
        send_request(flow_request(3, 3, 3, ax), 0);
        send_request(flow_request(-3, -3, 3, ax), 0);
    endtask

    initial begin
        int idle_pct[4] = '{0, 47, 0, 15};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        directed_set(1'b0);
        write_axis(1'b1);
        directed_set(1'b1);
        for (int ph = 0; ph < 4; ph++) begin
            write_axis(ph[0]);
            for (int n = 0; n < 235; n++) send_request(rand_request(), idle_pct[ph]);
        end
        i_start <= 1'b0;
        wait (pending == 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end
endmodule

// ===== hll_euler_flux_unit.f =====
+incdir+hdl
hdl/hll_pkg.sv
hdl/hll_div.sv
hdl/hll_euler_flux_unit.sv
test/hll_flux_checker.sv
test/tb_hll_euler_flux_unit.sv
